[rtl/core/wrss_pkg.sv]
`default_nettype none

package wrss_pkg;

    // Height word width used when the top level is not overridden
    localparam int unsigned HEIGHT_BITS_DEF = 16;

    // Configuration registers
    localparam int unsigned CFG_W     = 16;
    localparam int unsigned PADDR_W   = 3;
    localparam int unsigned PDATA_W   = 32;
    localparam logic [CFG_W-1:0] DT_GAIN_RST = 16'd0;
    localparam logic [CFG_W-1:0] FADE_RST    = 16'd64880;
    localparam logic REG_DT_GAIN = 1'b0;
    localparam logic REG_FADE    = 1'b1;

    // Normal path widths: slopes are always brought to 16 fraction bits
    localparam int unsigned SLOPE_W = 16;
    localparam int unsigned SQ_W    = 2 * SLOPE_W;
    localparam int unsigned D_W     = 37;
    localparam int unsigned R_W     = 26;
    localparam int unsigned R2_W    = 2 * R_W;
    localparam int unsigned LSQ_W   = 16;
    localparam int unsigned PROD_W  = LSQ_W + D_W;
    localparam int unsigned BYTE_W  = 8;

    // 2^34 is the "1 +" term of the normalizer, 765 = 255 * 3 (slope scale 1.5)
    localparam logic [D_W-1:0]  D_BASE  = D_W'(64'd1 << 34);
    localparam logic [9:0]      SLOPE_K = 10'd765;
    // Right-hand side of the z search, (255 * 2^17)^2
    localparam logic [R2_W-1:0] RZ2     = R2_W'(64'd65025 << 34);

    // Pipeline depth: front end, then three stages for each byte decision
    localparam int unsigned FRONT_STAGES  = 3;
    localparam int unsigned STEP_STAGES   = 3;
    localparam int unsigned PIPE_DEPTH    = FRONT_STAGES + STEP_STAGES * BYTE_W;
    localparam int unsigned HEIGHT_STAGES = 4;

    // Operands of one byte search lane
    typedef struct packed {
        logic [D_W-1:0]  d;
        logic [R2_W-1:0] r2;
        logic            rneg;
    } t_search_req;

endpackage

`default_nettype wire

[rtl/core/wrss_height_pipe.sv]
`default_nettype none

module wrss_height_pipe #(
    parameter int unsigned HEIGHT_BITS = wrss_pkg::HEIGHT_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_en,
    input  wire logic [wrss_pkg::CFG_W-1:0]   i_dt_gain,
    input  wire logic [wrss_pkg::CFG_W-1:0]   i_fade_factor,
    input  wire logic [HEIGHT_BITS-1:0]       i_center,
    input  wire logic [HEIGHT_BITS-1:0]       i_up,
    input  wire logic [HEIGHT_BITS-1:0]       i_down,
    input  wire logic [HEIGHT_BITS-1:0]       i_left,
    input  wire logic [HEIGHT_BITS-1:0]       i_right,
    input  wire logic [HEIGHT_BITS-1:0]       i_previous,
    output logic      [HEIGHT_BITS-1:0]       o_new_height,
    output logic      [wrss_pkg::BYTE_W-1:0]  o_height_byte
);

    localparam int unsigned HB     = HEIGHT_BITS;
    localparam int unsigned LAP_W  = HB + 3;
    localparam int unsigned BASE_W = HB + 2;
    localparam int unsigned ACC_W  = HB + 20;
    localparam int unsigned MAG_W  = HB + 19;
    localparam int unsigned SCL_W  = MAG_W + wrss_pkg::CFG_W;
    localparam int unsigned Q_W    = SCL_W - 30;
    localparam int unsigned BW     = wrss_pkg::BYTE_W;
    localparam int unsigned DLY    = wrss_pkg::PIPE_DEPTH - wrss_pkg::HEIGHT_STAGES;
    localparam int unsigned OUT_W  = HB + BW;

    logic [HB+1:0]             n1_sum;
    logic signed [LAP_W-1:0]   n1_lap;
    logic signed [BASE_W-1:0]  n1_base;
    logic [HB+BW-1:0]          n1_hprod;
    logic signed [LAP_W-1:0]   r1_lap;
    logic signed [BASE_W-1:0]  r1_base;
    logic [BW-1:0]             r1_hbyte;

    logic signed [ACC_W-1:0]   n2_prod;
    logic signed [ACC_W-1:0]   r2_prod;
    logic signed [ACC_W-1:0]   r2_base_sh;
    logic [BW-1:0]             r2_hbyte;

    logic signed [ACC_W-1:0]   n3_acc;
    logic                      r3_zero;
    logic [MAG_W-1:0]          r3_mag;
    logic [BW-1:0]             r3_hbyte;

    logic [SCL_W-1:0]          n4_scaled;
    logic [SCL_W-1:0]          r4_scaled;
    logic                      r4_zero;
    logic [BW-1:0]             r4_hbyte;

    logic [Q_W-1:0]            n5_q;
    logic [HB-1:0]             n5_nh;
    logic [OUT_W-1:0]          r_dly [DLY];

    // Stage 1: laplacian, 2c - p and the height byte
    always_comb begin
        n1_sum   = {2'b00, i_up} + {2'b00, i_down} + {2'b00, i_left} + {2'b00, i_right};
        n1_lap   = $signed({1'b0, n1_sum}) - $signed({1'b0, i_center, 2'b00});
        n1_base  = $signed({1'b0, i_center, 1'b0}) - $signed({2'b00, i_previous});
        n1_hprod = {i_center, 8'h00} - {8'h00, i_center};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_lap   <= n1_lap;
            r1_base  <= n1_base;
            r1_hbyte <= n1_hprod[HB+BW-1:HB];
        end
    end

    // Stage 2: gain times laplacian, align 2c - p to 14 more fraction bits
    always_comb begin
        n2_prod = $signed({{(LAP_W+1){1'b0}}, i_dt_gain})
                * $signed({{17{r1_lap[LAP_W-1]}}, r1_lap});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_prod    <= n2_prod;
            r2_base_sh <= {{4{r1_base[BASE_W-1]}}, r1_base, 14'd0};
            r2_hbyte   <= r1_hbyte;
        end
    end

    // Stage 3: accumulate, split off a non-positive sum
    always_comb begin
        n3_acc = r2_prod + r2_base_sh;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_zero  <= n3_acc[ACC_W-1] | (n3_acc == '0);
            r3_mag   <= n3_acc[MAG_W-1:0];
            r3_hbyte <= r2_hbyte;
        end
    end

    // Stage 4: apply the fade
    always_comb begin
        n4_scaled = {{wrss_pkg::CFG_W{1'b0}}, r3_mag} * {{MAG_W{1'b0}}, i_fade_factor};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_scaled <= n4_scaled;
            r4_zero   <= r3_zero;
            r4_hbyte  <= r3_hbyte;
        end
    end

    // Stage 5: drop 30 fraction bits and clamp to one
    always_comb begin
        n5_q = r4_scaled[SCL_W-1:30];
        if (r4_zero) begin
            n5_nh = '0;
        end else if (|n5_q[Q_W-1:HB]) begin
            n5_nh = '1;
        end else begin
            n5_nh = n5_q[HB-1:0];
        end
    end

    // Hold results until the normal lanes catch up
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dly[0] <= {n5_nh, r4_hbyte};
            for (int i = 1; i < DLY; i++) begin
                r_dly[i] <= r_dly[i-1];
            end
        end
    end

    assign o_new_height  = r_dly[DLY-1][OUT_W-1:BW];
    assign o_height_byte = r_dly[DLY-1][BW-1:0];

endmodule

`default_nettype wire

[rtl/core/wrss_slope_front.sv]
`default_nettype none

module wrss_slope_front #(
    parameter int unsigned HEIGHT_BITS = wrss_pkg::HEIGHT_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_en,
    input  wire logic [HEIGHT_BITS-1:0] i_up,
    input  wire logic [HEIGHT_BITS-1:0] i_down,
    input  wire logic [HEIGHT_BITS-1:0] i_left,
    input  wire logic [HEIGHT_BITS-1:0] i_right,
    output wrss_pkg::t_search_req       o_req_z,
    output wrss_pkg::t_search_req       o_req_x,
    output wrss_pkg::t_search_req       o_req_y
);

    localparam int unsigned HB   = HEIGHT_BITS;
    localparam int unsigned SW   = wrss_pkg::SLOPE_W;
    localparam int unsigned SQW  = wrss_pkg::SQ_W;
    localparam int unsigned DW   = wrss_pkg::D_W;
    localparam int unsigned RW   = wrss_pkg::R_W;
    localparam int unsigned R2W  = wrss_pkg::R2_W;

    logic            x_pos;
    logic            y_pos;
    logic [HB-1:0]   x_mag;
    logic [HB-1:0]   y_mag;
    logic [SW-1:0]   x_m16;
    logic [SW-1:0]   y_m16;
    logic [SW-1:0]   r1_mx;
    logic [SW-1:0]   r1_my;
    logic            r1_negx;
    logic            r1_negy;

    logic [SQW-1:0]  r2_sqx;
    logic [SQW-1:0]  r2_sqy;
    logic [RW-1:0]   r2_rx;
    logic [RW-1:0]   r2_ry;
    logic            r2_negx;
    logic            r2_negy;

    logic [SQW:0]    n3_sum;
    logic [DW-1:0]   r3_d;
    logic [R2W-1:0]  r3_rx2;
    logic [R2W-1:0]  r3_ry2;
    logic            r3_negx;
    logic            r3_negy;

    // Stage 1: slope magnitudes left minus right and down minus up
    always_comb begin
        x_pos = i_left >= i_right;
        y_pos = i_down >= i_up;
        x_mag = x_pos ? (i_left - i_right) : (i_right - i_left);
        y_mag = y_pos ? (i_down - i_up) : (i_up - i_down);
    end

    // Bring the magnitudes to 16 fraction bits
    if (HB >= SW) begin : g_trunc
        assign x_m16 = x_mag[HB-1 -: SW];
        assign y_m16 = y_mag[HB-1 -: SW];
    end else begin : g_widen
        assign x_m16 = {x_mag, {(SW-HB){1'b0}}};
        assign y_m16 = {y_mag, {(SW-HB){1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_mx   <= x_m16;
            r1_my   <= y_m16;
            // a slope that truncates to zero counts as non-negative
            r1_negx <= !x_pos && (|x_m16);
            r1_negy <= !y_pos && (|y_m16);
        end
    end

    // Stage 2: squared slopes and scaled right-hand sides
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_sqx  <= {{SW{1'b0}}, r1_mx} * {{SW{1'b0}}, r1_mx};
            r2_sqy  <= {{SW{1'b0}}, r1_my} * {{SW{1'b0}}, r1_my};
            r2_rx   <= {{(RW-SW){1'b0}}, r1_mx} * {{(RW-10){1'b0}}, wrss_pkg::SLOPE_K};
            r2_ry   <= {{(RW-SW){1'b0}}, r1_my} * {{(RW-10){1'b0}}, wrss_pkg::SLOPE_K};
            r2_negx <= r1_negx;
            r2_negy <= r1_negy;
        end
    end

    // Stage 3: normalizer 2^34 + 9 * (sx^2 + sy^2), squared right-hand sides
    always_comb begin
        n3_sum = {1'b0, r2_sqx} + {1'b0, r2_sqy};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_d    <= wrss_pkg::D_BASE + {1'b0, n3_sum, 3'b000} + {4'd0, n3_sum};
            r3_rx2  <= {{RW{1'b0}}, r2_rx} * {{RW{1'b0}}, r2_rx};
            r3_ry2  <= {{RW{1'b0}}, r2_ry} * {{RW{1'b0}}, r2_ry};
            r3_negx <= r2_negx;
            r3_negy <= r2_negy;
        end
    end

    assign o_req_z = '{d: r3_d, r2: wrss_pkg::RZ2, rneg: 1'b0};
    assign o_req_x = '{d: r3_d, r2: r3_rx2, rneg: r3_negx};
    assign o_req_y = '{d: r3_d, r2: r3_ry2, rneg: r3_negy};

endmodule

`default_nettype wire

[rtl/core/wrss_byte_search.sv]
`default_nettype none

// Finds the largest k in 0..255 with (2k - 255) * sqrt(d) <= r, one bit of k
// per three stages: square |2k-255|, multiply by d, compare against r^2.
module wrss_byte_search (
    input  wire logic                       i_clk,
    input  wire logic                       i_en,
    input  wire wrss_pkg::t_search_req      i_req,
    output logic [wrss_pkg::BYTE_W-1:0]     o_byte
);

    localparam int unsigned BW  = wrss_pkg::BYTE_W;
    localparam int unsigned LW  = wrss_pkg::LSQ_W;
    localparam int unsigned DW  = wrss_pkg::D_W;
    localparam int unsigned PW  = wrss_pkg::PROD_W;

    wrss_pkg::t_search_req r_a_req [BW];
    wrss_pkg::t_search_req r_b_req [BW];
    wrss_pkg::t_search_req r_c_req [BW-1];
    logic [BW-1:0]         r_a_k   [BW];
    logic [BW-1:0]         r_a_t   [BW];
    logic [LW-1:0]         r_a_sq  [BW];
    logic                  r_a_lpos[BW];
    logic [BW-1:0]         r_b_k   [BW];
    logic [BW-1:0]         r_b_t   [BW];
    logic [PW-1:0]         r_b_prod[BW];
    logic                  r_b_lpos[BW];
    logic [BW-1:0]         r_c_k   [BW];

    for (genvar j = 0; j < BW; j++) begin : g_bit
        wrss_pkg::t_search_req s_req;
        logic [BW-1:0]         s_k;
        logic [BW-1:0]         s_t;
        logic [BW:0]           s_labs;
        logic                  s_take;

        // Operands from the previous decision
        if (j == 0) begin : g_first
            assign s_req = i_req;
            assign s_k   = '0;
        end else begin : g_next
            assign s_req = r_c_req[j-1];
            assign s_k   = r_c_k[j-1];
        end

        // Stage A: candidate and |2t - 255|^2
        always_comb begin
            s_t    = s_k | BW'(8'h80 >> j);
            s_labs = s_t[BW-1] ? ({s_t, 1'b0} - 9'd255) : (9'd255 - {s_t, 1'b0});
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_a_req[j]  <= s_req;
                r_a_k[j]    <= s_k;
                r_a_t[j]    <= s_t;
                r_a_lpos[j] <= s_t[BW-1];
                r_a_sq[j]   <= {{BW{1'b0}}, s_labs[BW-1:0]} * {{BW{1'b0}}, s_labs[BW-1:0]};
            end
        end

        // Stage B: left-hand side (2t - 255)^2 * d
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_b_req[j]  <= r_a_req[j];
                r_b_k[j]    <= r_a_k[j];
                r_b_t[j]    <= r_a_t[j];
                r_b_lpos[j] <= r_a_lpos[j];
                r_b_prod[j] <= {{DW{1'b0}}, r_a_sq[j]} * {{LW{1'b0}}, r_a_req[j].d};
            end
        end

        // Stage C: keep the bit when the inequality holds
        always_comb begin
            if (!r_b_lpos[j] && !r_b_req[j].rneg) begin
                s_take = 1'b1;
            end else if (r_b_lpos[j] && r_b_req[j].rneg) begin
                s_take = 1'b0;
            end else if (r_b_lpos[j]) begin
                s_take = r_b_prod[j] <= {1'b0, r_b_req[j].r2};
            end else begin
                s_take = r_b_prod[j] >= {1'b0, r_b_req[j].r2};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_c_k[j] <= s_take ? r_b_t[j] : r_b_k[j];
            end
        end

        if (j < BW - 1) begin : g_pass
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_c_req[j] <= r_b_req[j];
                end
            end
        end
    end

    assign o_byte = r_c_k[BW-1];

endmodule

`default_nettype wire

[rtl/core/wave_ripple_stencil_step_unit.sv]
// Channel  | Handshake          | Payload
// ---------+--------------------+------------------------------------------
// cell in  | i_valid / o_ready  | i_height_center/up/down/left/right/previous
// texel out| o_valid / i_ready  | o_new_height, o_normal_{z,x,y}_byte, o_height_byte
// config   | psel/penable/pwrite| paddr, pwdata, prdata, pready (APB)
//
// One cell enters per clock unless the output buffer is full; the pipeline depth is
// set by the normal byte search: eight bit decisions of three stages each (square,
// multiply by the normalizer, compare) after a three-stage slope front end.
// Reset (i_rst_n low, synchronous) clears the stage valid bits, the output
// buffer and the registers (dt_gain 0, fade_factor 64880).
// A two-entry output buffer keeps the pipeline moving while a result waits;
// the pipeline stalls only when both entries are full, losing nothing.
`default_nettype none

module wave_ripple_stencil_step_unit #(
    parameter int unsigned HEIGHT_BITS = wrss_pkg::HEIGHT_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,

    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [HEIGHT_BITS-1:0]         i_height_center,
    input  wire logic [HEIGHT_BITS-1:0]         i_height_up,
    input  wire logic [HEIGHT_BITS-1:0]         i_height_down,
    input  wire logic [HEIGHT_BITS-1:0]         i_height_left,
    input  wire logic [HEIGHT_BITS-1:0]         i_height_right,
    input  wire logic [HEIGHT_BITS-1:0]         i_height_previous,

    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic      [HEIGHT_BITS-1:0]         o_new_height,
    output logic      [wrss_pkg::BYTE_W-1:0]    o_normal_z_byte,
    output logic      [wrss_pkg::BYTE_W-1:0]    o_normal_x_byte,
    output logic      [wrss_pkg::BYTE_W-1:0]    o_normal_y_byte,
    output logic      [wrss_pkg::BYTE_W-1:0]    o_height_byte,

    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [wrss_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [wrss_pkg::PDATA_W-1:0]   pwdata,
    output logic      [wrss_pkg::PDATA_W-1:0]   prdata,
    output logic                                pready
);

    localparam int unsigned DEPTH = wrss_pkg::PIPE_DEPTH;
    localparam int unsigned BW    = wrss_pkg::BYTE_W;
    localparam int unsigned CW    = wrss_pkg::CFG_W;
    localparam int unsigned AW    = wrss_pkg::PADDR_W;

    logic [CW-1:0]          r_dt_gain;
    logic [CW-1:0]          r_fade_factor;
    logic [DEPTH-1:0]       r_valid;
    logic                   pipe_en;
    logic                   push;
    logic                   pop;

    wrss_pkg::t_search_req  req_z;
    wrss_pkg::t_search_req  req_x;
    wrss_pkg::t_search_req  req_y;
    logic [HEIGHT_BITS-1:0] p_new_height;
    logic [BW-1:0]          p_height_byte;
    logic [BW-1:0]          p_z_byte;
    logic [BW-1:0]          p_x_byte;
    logic [BW-1:0]          p_y_byte;

    logic [HEIGHT_BITS-1:0] r_buf_nh [2];
    logic [BW-1:0]          r_buf_z  [2];
    logic [BW-1:0]          r_buf_x  [2];
    logic [BW-1:0]          r_buf_y  [2];
    logic [BW-1:0]          r_buf_h  [2];
    logic                   r_wr;
    logic                   r_rd;
    logic [1:0]             r_cnt;
    logic [1:0]             n_cnt;

    // Configuration writes
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt_gain     <= wrss_pkg::DT_GAIN_RST;
            r_fade_factor <= wrss_pkg::FADE_RST;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[AW-1])
                wrss_pkg::REG_DT_GAIN: r_dt_gain     <= pwdata[CW-1:0];
                wrss_pkg::REG_FADE:    r_fade_factor <= pwdata[CW-1:0];
                default:               r_dt_gain     <= r_dt_gain;
            endcase
        end
    end

    // Register read back; an unaligned address reads zero
    always_comb begin
        prdata = '0;
        if (paddr[AW-2:0] == '0) begin
            case (paddr[AW-1])
                wrss_pkg::REG_DT_GAIN: prdata = {{(wrss_pkg::PDATA_W-CW){1'b0}}, r_dt_gain};
                wrss_pkg::REG_FADE:    prdata = {{(wrss_pkg::PDATA_W-CW){1'b0}}, r_fade_factor};
                default:               prdata = '0;
            endcase
        end
    end

    // Advance the pipeline unless the output buffer is full
    assign pipe_en = (r_cnt != 2'd2);
    assign o_ready = pipe_en;
    assign push    = pipe_en && r_valid[DEPTH-1];
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (pipe_en) begin
            r_valid <= {r_valid[DEPTH-2:0], i_valid};
        end
    end

    wrss_height_pipe #(
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_height (
        .i_clk         (i_clk),
        .i_en          (pipe_en),
        .i_dt_gain     (r_dt_gain),
        .i_fade_factor (r_fade_factor),
        .i_center      (i_height_center),
        .i_up          (i_height_up),
        .i_down        (i_height_down),
        .i_left        (i_height_left),
        .i_right       (i_height_right),
        .i_previous    (i_height_previous),
        .o_new_height  (p_new_height),
        .o_height_byte (p_height_byte)
    );

    wrss_slope_front #(
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_en    (pipe_en),
        .i_up    (i_height_up),
        .i_down  (i_height_down),
        .i_left  (i_height_left),
        .i_right (i_height_right),
        .o_req_z (req_z),
        .o_req_x (req_x),
        .o_req_y (req_y)
    );

    wrss_byte_search u_search_z (
        .i_clk  (i_clk),
        .i_en   (pipe_en),
        .i_req  (req_z),
        .o_byte (p_z_byte)
    );

    wrss_byte_search u_search_x (
        .i_clk  (i_clk),
        .i_en   (pipe_en),
        .i_req  (req_x),
        .o_byte (p_x_byte)
    );

    wrss_byte_search u_search_y (
        .i_clk  (i_clk),
        .i_en   (pipe_en),
        .i_req  (req_y),
        .o_byte (p_y_byte)
    );

    // Output buffer: two entries, written in order, read in order
    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!push && pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wr <= !r_wr;
            end
            if (pop) begin
                r_rd <= !r_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf_nh[r_wr] <= p_new_height;
            r_buf_z[r_wr]  <= p_z_byte;
            r_buf_x[r_wr]  <= p_x_byte;
            r_buf_y[r_wr]  <= p_y_byte;
            r_buf_h[r_wr]  <= p_height_byte;
        end
    end

    assign o_valid         = (r_cnt != 2'd0);
    assign o_new_height    = r_buf_nh[r_rd];
    assign o_normal_z_byte = r_buf_z[r_rd];
    assign o_normal_x_byte = r_buf_x[r_rd];
    assign o_normal_y_byte = r_buf_y[r_rd];
    assign o_height_byte   = r_buf_h[r_rd];

`ifndef SYNTHESIS
    a_buf_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("output buffer count out of range");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !pipe_en |=> $stable(r_valid))
        else $error("pipeline moved while stalled");

    a_exit_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> o_valid)
        else $error("item left the pipeline but no result is offered");
`endif

endmodule

`default_nettype wire
